// File: rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// shared types and constants of the line tracking pd steering block
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int DEF_NUM_SENSORS = 5;
  localparam int DEF_LEVEL_BITS  = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ON_LINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_RATIO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_RATIO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_RATIO = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_CAL, S_NORM, S_NDIV, S_NWR,
    S_COLR, S_COLG, S_COLB, S_COLCHK,
    S_RDL, S_RDM, S_RDR, S_RDCAP, S_NBR, S_TDIV, S_LIN,
    S_SNAP, S_RED, S_MULP, S_MULD, S_ACC, S_OUT
  } state_t;

  typedef enum logic [2:0] {MUL_NONE, MUL_R, MUL_G, MUL_B, MUL_P, MUL_D, MUL_LIN} mul_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_R, CHK_G, CHK_B} chk_t;
  typedef enum logic [1:0] {NB_NONE, NB_L, NB_M, NB_R} nb_t;

  typedef struct packed {
    logic latch;
    logic cal;
    logic norm;
    logic frac_wr;
    mul_t mul;
    chk_t chk;
    nb_t  rd;
    nb_t  cap;
    logic nbr;
    logic lin;
    logic snap;
    logic red;
    logic pd_first;
    logic pd_acc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic run;
    logic last;
    logic norm_special;
    logic div_busy;
    logic need_div;
    logic out_free;
  } status_t;

endpackage

// File: rtl/lps_div.sv
// ----------------------------------------------------------------------------
// lps_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lps_div #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [LEVEL_BITS-1:0] rem_init,
  input  logic [15:0]           word_init,
  input  logic [4:0]            count_init,
  input  logic [LEVEL_BITS-1:0] divisor,
  output logic                  busy,
  output logic [15:0]           quot
);

  logic [LEVEL_BITS-1:0] rem;
  logic [LEVEL_BITS-1:0] dvs;
  logic [15:0]           word;
  logic [4:0]            cnt;
  logic [LEVEL_BITS:0]   trial;
  logic                  ge;

  always_comb begin
    trial = {rem, word[15]};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= count_init;
    end else if (busy) begin
      cnt  <= cnt - 5'd1;
      busy <= (cnt != 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= rem_init;
      word <= word_init;
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? LEVEL_BITS'(trial - {1'b0, dvs}) : LEVEL_BITS'(trial);
      word <= {word[14:0], 1'b0};
      quot <= {quot[14:0], ge};
    end
  end

endmodule

// File: rtl/lps_ctrl.sv
// ----------------------------------------------------------------------------
// lps_ctrl
// sequencer for calibration, normalization, colour checks and steering
// ----------------------------------------------------------------------------
module lps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lps_pkg::status_t status,
  output lps_pkg::cmd_t    cmd
);
  import lps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DISP;
      S_DISP: begin
        if (!status.idx_ok) begin
          state_next = (status.run && status.last) ? S_RDL : S_IDLE;
        end else if (!status.run) begin
          state_next = S_CAL;
        end else begin
          state_next = S_NORM;
        end
      end
      S_CAL:    state_next = S_IDLE;
      S_NORM:   state_next = status.norm_special ? S_NWR : S_NDIV;
      S_NDIV:   if (!status.div_busy) state_next = S_NWR;
      S_NWR:    state_next = S_COLR;
      S_COLR:   state_next = S_COLG;
      S_COLG:   state_next = S_COLB;
      S_COLB:   state_next = S_COLCHK;
      S_COLCHK: state_next = status.last ? S_RDL : S_IDLE;
      S_RDL:    state_next = S_RDM;
      S_RDM:    state_next = S_RDR;
      S_RDR:    state_next = S_RDCAP;
      S_RDCAP:  state_next = S_NBR;
      S_NBR:    state_next = status.need_div ? S_TDIV : S_SNAP;
      S_TDIV:   state_next = S_LIN;
      S_LIN:    state_next = S_SNAP;
      S_SNAP:   state_next = S_RED;
      S_RED:    state_next = S_MULP;
      S_MULP:   state_next = S_MULD;
      S_MULD:   state_next = S_ACC;
      S_ACC:    state_next = S_OUT;
      S_OUT:    if (status.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul  = MUL_NONE;
    cmd.chk  = CHK_NONE;
    cmd.rd   = NB_NONE;
    cmd.cap  = NB_NONE;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE:   cmd.latch = in_valid;
      S_CAL:    cmd.cal = 1'b1;
      S_NORM:   cmd.norm = 1'b1;
      S_NWR:    cmd.frac_wr = 1'b1;
      S_COLR:   cmd.mul = MUL_R;
      S_COLG: begin
        cmd.chk = CHK_R;
        cmd.mul = MUL_G;
      end
      S_COLB: begin
        cmd.chk = CHK_G;
        cmd.mul = MUL_B;
      end
      S_COLCHK: cmd.chk = CHK_B;
      S_RDL:    cmd.rd = NB_L;
      S_RDM: begin
        cmd.rd  = NB_M;
        cmd.cap = NB_L;
      end
      S_RDR: begin
        cmd.rd  = NB_R;
        cmd.cap = NB_M;
      end
      S_RDCAP:  cmd.cap = NB_R;
      S_NBR:    cmd.nbr = 1'b1;
      S_TDIV:   cmd.mul = MUL_LIN;
      S_LIN:    cmd.lin = 1'b1;
      S_SNAP:   cmd.snap = 1'b1;
      S_RED:    cmd.red = 1'b1;
      S_MULP:   cmd.mul = MUL_P;
      S_MULD: begin
        cmd.mul      = MUL_D;
        cmd.pd_first = 1'b1;
      end
      S_ACC:    cmd.pd_acc = 1'b1;
      S_OUT:    cmd.fin = status.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: rtl/lps_dp.sv
// ----------------------------------------------------------------------------
// lps_dp
// datapath: calibration ranges, level memory, colour flags, tracking, pd
// ----------------------------------------------------------------------------
module lps_dp #(
  parameter int NUM_SENSORS = 5,
  parameter int LEVEL_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lps_pkg::cmd_t                    cmd,
  output lps_pkg::status_t                 status,
  input  logic                             cfg_write,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             command,
  input  logic [2:0]                       sensor_index,
  input  logic [15:0]                      clear_level,
  input  logic [15:0]                      red_level,
  input  logic [15:0]                      green_level,
  input  logic [15:0]                      blue_level,
  input  logic                             frame_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               steer_error,
  output logic signed [15:0]               left_speed,
  output logic signed [15:0]               right_speed,
  output logic signed [2:0]                tracked_position,
  output logic                             moving_left,
  output logic                             moving_right,
  output logic                             stop_request
);
  import lps_pkg::*;

  localparam int LB    = LEVEL_BITS;
  localparam int AW    = $clog2(NUM_SENSORS);
  localparam int PW    = $clog2(NUM_SENSORS) + 1;
  localparam int EW    = 20;
  localparam int EDGE  = (NUM_SENSORS - 1) / 2;
  localparam logic signed [PW-1:0] P_LO   = PW'(-EDGE);
  localparam logic signed [PW-1:0] P_HI   = PW'(EDGE);
  localparam logic signed [PW:0]   EDGE_S = (PW+1)'(EDGE);
  localparam logic signed [PW:0]   OFF_L  = -(PW+1)'(1);
  localparam logic signed [PW:0]   OFF_M  = (PW+1)'(0);
  localparam logic signed [PW:0]   OFF_R  = (PW+1)'(1);
  // reciprocals of 13 and 7, scaled by 2^20 and 2^19
  localparam logic signed [18:0]   RCP_EDGE = 19'sd80661;
  localparam logic signed [18:0]   RCP_MID  = 19'sd74899;

  function automatic logic signed [PW:0] sidx(input logic signed [PW-1:0] pp,
                                               input logic signed [PW:0] off);
    sidx = {pp[PW-1], pp} + off + EDGE_S;
  endfunction

  function automatic logic in_range(input logic signed [PW:0] i);
    in_range = !i[PW] && ($unsigned(i) < (PW+1)'(NUM_SENSORS));
  endfunction

  function automatic logic flag_at(input logic [NUM_SENSORS-1:0] v,
                                   input logic signed [PW:0] i);
    logic r;
    r = 1'b0;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (i == (PW+1)'(k)) r = v[k];
    end
    flag_at = r;
  endfunction

  function automatic logic signed [EW-1:0] pos_scaled(input logic signed [PW-1:0] pp);
    pos_scaled = {{(EW-PW-12){pp[PW-1]}}, pp, 12'b0};
  endfunction

  function automatic logic near_pos(input logic signed [EW-1:0] ev,
                                    input logic signed [PW-1:0] pp,
                                    input logic [14:0] thr);
    logic signed [EW-1:0] ps;
    logic signed [EW:0] d;
    logic [EW:0]        m;
    ps = pos_scaled(pp);
    d = {ev[EW-1], ev} - {ps[EW-1], ps};
    m = d[EW] ? $unsigned(-d) : $unsigned(d);
    near_pos = {m, 2'b0} < (EW+3)'(thr);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    if (v > 28'sd32767) sat16 = 16'sh7fff;
    else if (v < -28'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

  // configuration
  logic [14:0] on_line_threshold;
  logic [14:0] near_threshold;
  logic [15:0] prop_gain;
  logic [15:0] deriv_gain;
  logic [12:0] base_speed;
  logic [15:0] red_ratio;
  logic [15:0] green_ratio;
  logic [15:0] blue_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_line_threshold <= 15'd9830;
      near_threshold    <= 15'd1638;
      prop_gain         <= 16'd369;
      deriv_gain        <= 16'd287;
      base_speed        <= 13'd901;
      red_ratio         <= 16'd26870;
      green_ratio       <= 16'd28180;
      blue_ratio        <= 16'd37356;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ON_LINE:     on_line_threshold <= cfg_data[14:0];
        CFG_NEAR:        near_threshold    <= cfg_data[14:0];
        CFG_PROP_GAIN:   prop_gain         <= cfg_data;
        CFG_DERIV_GAIN:  deriv_gain        <= cfg_data;
        CFG_BASE_SPEED:  base_speed        <= cfg_data[12:0];
        CFG_RED_RATIO:   red_ratio         <= cfg_data;
        CFG_GREEN_RATIO: green_ratio       <= cfg_data;
        CFG_BLUE_RATIO:  blue_ratio        <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat
  logic          in_run;
  logic          in_last;
  logic [2:0]    in_idx;
  logic [LB-1:0] in_clr;
  logic [LB-1:0] in_red;
  logic [LB-1:0] in_grn;
  logic [LB-1:0] in_blu;
  logic [LB+1:0] in_tot;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_run  <= command;
      in_last <= frame_end;
      in_idx  <= sensor_index;
      in_clr  <= clear_level[LB-1:0];
      in_red  <= red_level[LB-1:0];
      in_grn  <= green_level[LB-1:0];
      in_blu  <= blue_level[LB-1:0];
      in_tot  <= (LB+2)'(red_level[LB-1:0]) + (LB+2)'(green_level[LB-1:0])
               + (LB+2)'(blue_level[LB-1:0]);
    end
  end

  logic [AW-1:0] in_addr;
  logic          idx_ok;
  assign in_addr = AW'(in_idx);
  assign idx_ok  = 32'(in_idx) < 32'(NUM_SENSORS);

  // calibration range
  logic [LB-1:0] min_clear [NUM_SENSORS];
  logic [LB-1:0] max_clear [NUM_SENSORS];
  logic [LB-1:0] cur_min;
  logic [LB-1:0] cur_max;
  assign cur_min = min_clear[in_addr];
  assign cur_max = max_clear[in_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
        min_clear[k] <= '1;
        max_clear[k] <= '0;
      end
    end else if (cmd.cal) begin
      if (in_clr < cur_min) begin
        min_clear[in_addr] <= in_clr;
      end else if (in_clr > cur_max) begin
        max_clear[in_addr] <= in_clr;
      end
    end
  end

  // divider for normalization
  logic          div_load;
  logic [LB-1:0] div_rem;
  logic [15:0]   div_word;
  logic [4:0]    div_cnt;
  logic [LB-1:0] div_dvs;
  logic          div_busy;
  logic [15:0]   div_quot;

  lps_div #(.LEVEL_BITS(LB)) u_div (
    .clk        (clk),
    .rst        (rst),
    .load       (div_load),
    .rem_init   (div_rem),
    .word_init  (div_word),
    .count_init (div_cnt),
    .divisor    (div_dvs),
    .busy       (div_busy),
    .quot       (div_quot)
  );

  // normalization
  logic [LB-1:0] n_diff;
  logic [LB-1:0] n_den;
  logic          n_special;
  logic [15:0]   n_value;

  always_comb begin
    n_diff = in_clr - cur_min;
    n_den  = cur_max - cur_min;
    if (in_clr <= cur_min) begin
      n_special = 1'b1;
      n_value   = '0;
    end else if (cur_max <= cur_min) begin
      n_special = 1'b1;
      n_value   = '1;
    end else if ({2'b0, n_diff} >= {n_den, 2'b0}) begin
      n_special = 1'b1;
      n_value   = '1;
    end else begin
      n_special = 1'b0;
      n_value   = '0;
    end
  end

  // level memory
  logic [15:0]   frac_mem [NUM_SENSORS];
  logic [15:0]   frac_rd;
  logic          frac_rd_ok;
  logic signed [PW:0] rd_i;
  logic signed [PW-1:0] position;

  always_comb begin
    case (cmd.rd)
      NB_L:    rd_i = sidx(position, OFF_L);
      NB_R:    rd_i = sidx(position, OFF_R);
      default: rd_i = sidx(position, OFF_M);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.frac_wr) begin
      frac_mem[in_addr] <= n_special ? n_value : div_quot;
    end
    if (cmd.rd != NB_NONE) begin
      frac_rd    <= frac_mem[AW'(rd_i)];
      frac_rd_ok <= in_range(rd_i);
    end
  end

  logic [15:0] fl;
  logic [15:0] fm;
  logic [15:0] fr;

  always_ff @(posedge clk) begin
    case (cmd.cap)
      NB_L:    fl <= frac_rd_ok ? frac_rd : '0;
      NB_M:    fm <= frac_rd_ok ? frac_rd : '0;
      NB_R:    fr <= frac_rd_ok ? frac_rd : '0;
      default: ;
    endcase
  end

  // shared multiplier
  logic signed [18:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [35:0] prod;
  logic signed [EW-1:0] err;
  logic signed [15:0] err_sat;
  logic signed [15:0] last_error;
  logic signed [16:0] err_diff;
  logic [15:0]        lin_y;
  logic               lin_edge;

  assign err_sat  = sat16(28'(err));
  assign err_diff = {err_sat[15], err_sat} - {last_error[15], last_error};

  always_comb begin
    case (cmd.mul)
      MUL_R: begin
        mul_a = $signed(19'(in_tot));
        mul_b = $signed({1'b0, red_ratio});
      end
      MUL_G: begin
        mul_a = $signed(19'(in_tot));
        mul_b = $signed({1'b0, green_ratio});
      end
      MUL_B: begin
        mul_a = $signed(19'(in_tot));
        mul_b = $signed({1'b0, blue_ratio});
      end
      MUL_P: begin
        mul_a = 19'(err_sat);
        mul_b = $signed({1'b0, prop_gain});
      end
      MUL_D: begin
        mul_a = 19'(err_diff);
        mul_b = $signed({1'b0, deriv_gain});
      end
      MUL_LIN: begin
        mul_a = lin_edge ? RCP_EDGE : RCP_MID;
        mul_b = $signed({1'b0, lin_y});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  // colour flags
  logic [NUM_SENSORS-1:0] red_flags;
  logic [NUM_SENSORS-1:0] green_flags;
  logic                   blue_seen;
  logic [LB-1:0]          chk_chan;
  logic                   hit;

  always_comb begin
    case (cmd.chk)
      CHK_R:   chk_chan = in_red;
      CHK_G:   chk_chan = in_grn;
      default: chk_chan = in_blu;
    endcase
    hit = (in_tot != '0) && ($unsigned(prod) <= 36'({chk_chan, 16'b0}));
  end

  // tracking
  logic                 left_flag;
  logic                 right_flag;
  logic                 mid_branch;
  logic                 lin_sign;
  logic                 need_div;
  logic                 nb_lf;
  logic                 nb_rf;
  logic                 nb_sgn;
  logic [15:0]          nb_fe;
  logic                 use_edge;
  logic signed [22:0]   lin_num;
  logic                 lin_neg;
  logic [22:0]          lin_mag;
  logic [22:0]          lin_d;
  logic                 fl_on;
  logic                 fm_on;
  logic                 fr_on;
  logic signed [EW-1:0] lin_term;
  logic                 snap_m;
  logic                 snap_l;
  logic                 snap_r;

  always_comb begin
    fl_on = fl <= 16'(on_line_threshold);
    fm_on = fm <= 16'(on_line_threshold);
    fr_on = fr <= 16'(on_line_threshold);
    nb_lf = left_flag;
    nb_rf = right_flag;
    if (fl_on && !flag_at(green_flags, sidx(position, OFF_L))) begin
      nb_lf = 1'b1;
      nb_rf = 1'b0;
    end else if (fr_on && !flag_at(green_flags, sidx(position, OFF_R))) begin
      nb_lf = 1'b0;
      nb_rf = 1'b1;
    end
    if (nb_lf) begin
      nb_fe  = fl;
      nb_sgn = (position <= PW'(1));
    end else begin
      nb_fe  = fr;
      nb_sgn = (position < -PW'(1));
    end
    use_edge = nb_fe <= 16'(on_line_threshold);
    need_div = (position != P_LO) && (position != P_HI) && (nb_lf || nb_rf)
             && (use_edge || fm_on);
    if (use_edge) begin
      lin_num = 23'sd442368 - $signed(23'({nb_fe, 4'b0}) + 23'({nb_fe, 2'b0}));
    end else begin
      lin_num = $signed(23'({fm, 2'b0}) + 23'(fm));
    end
    lin_neg  = lin_num[22];
    lin_mag  = lin_neg ? $unsigned(-lin_num) : $unsigned(lin_num);
    lin_d    = lin_mag + (use_edge ? 23'd52 : 23'd14);
    // divide by 104 as (x >> 3) / 13, by 28 as (x >> 2) / 7
    lin_term = lin_edge ? $signed(EW'(prod[32:20])) : $signed(EW'(prod[31:19]));
    snap_m = near_pos(err, position, near_threshold)
           && !flag_at(green_flags, sidx(position, OFF_M));
    snap_l = near_pos(err, position - PW'(1), near_threshold)
           && !flag_at(green_flags, sidx(position, OFF_L));
    snap_r = near_pos(err, position + PW'(1), near_threshold)
           && !flag_at(green_flags, sidx(position, OFF_R));
  end

  always_comb begin
    div_load = 1'b0;
    div_rem  = '0;
    div_word = '0;
    div_cnt  = '0;
    div_dvs  = '0;
    if (cmd.norm && !n_special) begin
      div_load = 1'b1;
      div_rem  = n_diff >> 2;
      div_word = {n_diff[1:0], 14'b0};
      div_cnt  = 5'd16;
      div_dvs  = n_den;
    end
  end

  // pd sum
  logic signed [37:0] pd;
  logic [37:0]        pd_mag;
  logic [25:0]        pd_rnd;
  logic signed [27:0] pid_full;
  logic signed [15:0] pid;
  logic signed [27:0] ls_full;
  logic signed [27:0] rs_full;

  always_comb begin
    pd_mag   = pd[37] ? $unsigned(-pd) : $unsigned(pd);
    pd_rnd   = 26'((pd_mag + 38'd2048) >> 12);
    pid_full = pd[37] ? -$signed({2'b0, pd_rnd}) : $signed({2'b0, pd_rnd});
    pid      = sat16(pid_full);
    ls_full  = $signed(28'(base_speed)) + 28'(pid);
    rs_full  = $signed(28'(base_speed)) - 28'(pid);
  end

  always_ff @(posedge clk) begin
    if (cmd.pd_first) begin
      pd <= 38'(prod);
    end else if (cmd.pd_acc) begin
      pd <= pd + 38'(prod);
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      red_flags   <= '0;
      green_flags <= '0;
      blue_seen   <= 1'b0;
      position    <= '0;
      left_flag   <= 1'b0;
      right_flag  <= 1'b0;
      last_error  <= '0;
      out_valid   <= 1'b0;
    end else begin
      case (cmd.chk)
        CHK_R:   red_flags[in_addr] <= hit;
        CHK_G:   green_flags[in_addr] <= hit;
        CHK_B:   if (hit) blue_seen <= 1'b1;
        default: ;
      endcase
      if (cmd.nbr) begin
        err        <= pos_scaled(position);
        mid_branch <= 1'b0;
        if (position == P_LO) begin
          if (fr_on) begin
            left_flag  <= 1'b1;
            right_flag <= 1'b0;
            position   <= position + PW'(1);
          end
        end else if (position == P_HI) begin
          if (fl_on) begin
            right_flag <= 1'b1;
            left_flag  <= 1'b0;
            position   <= position - PW'(1);
          end
        end else begin
          mid_branch <= 1'b1;
          left_flag  <= nb_lf;
          right_flag <= nb_rf;
          lin_sign   <= nb_sgn ^ lin_neg;
          lin_edge   <= use_edge;
          lin_y      <= use_edge ? lin_d[18:3] : lin_d[17:2];
          if ((nb_lf || nb_rf) && !need_div) begin
            err <= nb_sgn ? pos_scaled(position) - EW'(2048)
                          : pos_scaled(position) + EW'(2048);
          end
        end
      end
      if (cmd.lin) begin
        err <= lin_sign ? pos_scaled(position) - lin_term
                        : pos_scaled(position) + lin_term;
      end
      if (cmd.snap && mid_branch) begin
        if (snap_m) begin
          err        <= pos_scaled(position);
          left_flag  <= 1'b0;
          right_flag <= 1'b0;
        end else if (snap_l) begin
          err        <= pos_scaled(position - PW'(1));
          position   <= position - PW'(1);
          left_flag  <= 1'b0;
          right_flag <= 1'b0;
        end else if (snap_r) begin
          err        <= pos_scaled(position + PW'(1));
          position   <= position + PW'(1);
          left_flag  <= 1'b0;
          right_flag <= 1'b0;
        end
      end
      if (cmd.red) begin
        if (red_flags[NUM_SENSORS-1]) begin
          err        <= pos_scaled(P_HI);
          position   <= P_HI;
          left_flag  <= 1'b0;
          right_flag <= 1'b0;
        end else if (red_flags[0]) begin
          err        <= pos_scaled(P_LO);
          position   <= P_LO;
          left_flag  <= 1'b0;
          right_flag <= 1'b0;
        end else if (red_flags[EDGE-1]) begin
          position   <= -PW'(1);
          left_flag  <= 1'b0;
          right_flag <= 1'b0;
        end else if (red_flags[EDGE+1]) begin
          position   <= PW'(1);
          left_flag  <= 1'b0;
          right_flag <= 1'b0;
        end else if (red_flags[EDGE]) begin
          position   <= '0;
          left_flag  <= 1'b0;
          right_flag <= 1'b0;
        end
      end
      if (cmd.fin) begin
        out_valid   <= 1'b1;
        last_error  <= err_sat;
        red_flags   <= '0;
        green_flags <= '0;
        blue_seen   <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      steer_error      <= err_sat;
      left_speed       <= sat16(ls_full);
      right_speed      <= sat16(rs_full);
      tracked_position <= position[2:0];
      moving_left      <= left_flag;
      moving_right     <= right_flag;
      stop_request     <= blue_seen;
    end
  end

  always_comb begin
    status.idx_ok       = idx_ok;
    status.run          = in_run;
    status.last         = in_last;
    status.norm_special = n_special;
    status.div_busy     = div_busy;
    status.need_div     = need_div;
    status.out_free     = !out_valid || !out_stall;
  end

endmodule

// File: rtl/line_tracking_pd_steering_top.sv
// ----------------------------------------------------------------------------
// line_tracking_pd_steering_top
// colour sensor line follower with pd steering
// ----------------------------------------------------------------------------
// One reading of one sensor is taken per beat, one at a time. A run beat
// normalizes the clear level with the 16 steps of the restoring divider,
// then runs the colour checks on the shared multiplier; the division is
// skipped when the level needs none (at or below the minimum, an empty
// range, or a saturated fraction). A run beat that closes a frame then does
// three reads of the level memory, one reciprocal multiply when the
// linearized error is needed, and two multiplier passes for the pd sum,
// plus any wait for the previous result to leave. One result beat leaves
// per closed run frame; the next reading is taken while that result waits.
module line_tracking_pd_steering_top #(
  parameter int NUM_SENSORS = lps_pkg::DEF_NUM_SENSORS,
  parameter int LEVEL_BITS  = lps_pkg::DEF_LEVEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [2:0]                     sensor_index,
  input  logic [15:0]                    clear_level,
  input  logic [15:0]                    red_level,
  input  logic [15:0]                    green_level,
  input  logic [15:0]                    blue_level,
  input  logic                           frame_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             steer_error,
  output logic signed [15:0]             left_speed,
  output logic signed [15:0]             right_speed,
  output logic signed [2:0]              tracked_position,
  output logic                           moving_left,
  output logic                           moving_right,
  output logic                           stop_request,
  input  logic                           cfg_write,
  input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lps_pkg::*;

  cmd_t    cmd;
  status_t status;

  lps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lps_dp #(
    .NUM_SENSORS (NUM_SENSORS),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .command          (command),
    .sensor_index     (sensor_index),
    .clear_level      (clear_level),
    .red_level        (red_level),
    .green_level      (green_level),
    .blue_level       (blue_level),
    .frame_end        (frame_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .steer_error      (steer_error),
    .left_speed       (left_speed),
    .right_speed      (right_speed),
    .tracked_position (tracked_position),
    .moving_left      (moving_left),
    .moving_right     (moving_right),
    .stop_request     (stop_request)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !(out_valid && out_stall))
    else $error("result loaded over a pending result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while busy");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(moving_left && moving_right))
    else $error("moving left and right at once");
`endif

endmodule

// File: test/line_tracking_pd_steering_top_tb.sv
// ----------------------------------------------------------------------------
// line_tracking_pd_steering_top_tb
// self-checking bench for the colour sensor line follower with pd steering
// ----------------------------------------------------------------------------
// Sensor readings go in from a queue through a clocked driver, and a clocked
// monitor checks every steering beat against a predictor of calibration,
// normalization, colour flags, line tracking and pd control. The run passes
// through several register settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module line_tracking_pd_steering_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lps_pkg::*;

  localparam int NSENS = 5;
  localparam int EDGE = 2;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    bit          run;
    logic [2:0]  idx;
    logic [15:0] clr, red, grn, blu;
    bit          last;
  } reading_t;

  typedef struct {
    logic signed [15:0] err, ls, rs;
    logic signed [2:0]  pos;
    logic               ml, mr, stop;
  } steer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [2:0] sensor_index = '0;
  logic [15:0] clear_level = '0, red_level = '0, green_level = '0, blue_level = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] steer_error, left_speed, right_speed;
  logic signed [2:0] tracked_position;
  logic moving_left, moving_right, stop_request;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  line_tracking_pd_steering_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  int unsigned on_line_thr = 9830, near_thr = 1638, kp = 369, kd = 287, base_spd = 901;
  int unsigned red_rat = 26870, grn_rat = 28180, blu_rat = 37356;
  int unsigned min_clr[NSENS], max_clr[NSENS], frac[NSENS];
  logic [NSENS-1:0] red_seen = '0, grn_seen = '0;
  bit blue_hit = 0, go_left = 0, go_right = 0;
  int track_pos = 0, prev_err = 0;

  reading_t reading_q[$];
  steer_t steer_q[$];
  reading_t cur;
  bit took = 0;
  bit hold = 0;
  int snd_idle = 0, rcv_idle = 0;
  int errors = 0;
  int quiet = 0;

  initial begin
    for (int i = 0; i < NSENS; i++) begin
      min_clr[i] = 16'hFFFF;
      max_clr[i] = 0;
      frac[i] = 0;
    end
  end

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint frac_of(int i);
    if (i < 0 || i >= NSENS) return 0;
    return frac[i];
  endfunction

  function automatic bit green_at(int i);
    if (i < 0 || i >= NSENS) return 0;
    return grn_seen[i];
  endfunction

  function automatic bit red_at(int i);
    if (i < 0 || i >= NSENS) return 0;
    return red_seen[i];
  endfunction

  function automatic bit colour_hit(int unsigned ratio, int unsigned chan, int unsigned total);
    if (total == 0) return 0;
    return longint'(ratio) * total <= (longint'(chan) << 16);
  endfunction

  function automatic int line_error(int edg, int mid);
    longint sgn, fe, fm, term;
    sgn = (edg < 0 || (edg == 0 && mid == 1)) ? -1 : 1;
    fe = frac_of(edg + EDGE);
    fm = frac_of(mid + EDGE);
    if (fe <= on_line_thr) term = round_div(27 * 16384 - 20 * fe, 104);
    else if (fm <= on_line_thr) term = round_div(5 * fm, 28);
    else term = 2048;
    return int'(longint'(mid) * 4096 + sgn * term);
  endfunction

  function automatic bit near_to(int e, int p);
    longint d;
    d = longint'(e) - longint'(p) * 4096;
    if (d < 0) d = -d;
    return d * 4 < near_thr;
  endfunction

  task automatic predict_steering(reading_t it);
    int unsigned total, f;
    longint q, pd;
    int e, p, pid, ls, rs, ix;
    steer_t s;
    ix = it.idx;
    if (ix < NSENS) begin
      if (!it.run) begin
        if (it.clr < min_clr[ix]) min_clr[ix] = it.clr;
        else if (it.clr > max_clr[ix]) max_clr[ix] = it.clr;
      end else begin
        total = it.red + it.grn + it.blu;
        if (it.clr <= min_clr[ix]) f = 0;
        else if (max_clr[ix] <= min_clr[ix]) f = 65535;
        else begin
          q = (longint'(it.clr - min_clr[ix]) << 14) / longint'(max_clr[ix] - min_clr[ix]);
          f = q > 65535 ? 65535 : int'(q);
        end
        frac[ix] = f;
        red_seen[ix] = colour_hit(red_rat, it.red, total);
        grn_seen[ix] = colour_hit(grn_rat, it.grn, total);
        if (colour_hit(blu_rat, it.blu, total)) blue_hit = 1;
      end
    end
    if (!it.run || !it.last) return;
    p = track_pos;
    e = p * 4096;
    if (p == -EDGE) begin
      if (frac_of(p + 1 + EDGE) <= on_line_thr) begin
        go_left = 1; go_right = 0; p = p + 1;
      end
    end else if (p == EDGE) begin
      if (frac_of(p - 1 + EDGE) <= on_line_thr) begin
        go_right = 1; go_left = 0; p = p - 1;
      end
    end else begin
      if (frac_of(p - 1 + EDGE) <= on_line_thr && !green_at(p - 1 + EDGE)) begin
        go_left = 1; go_right = 0;
      end else if (frac_of(p + 1 + EDGE) <= on_line_thr && !green_at(p + 1 + EDGE)) begin
        go_right = 1; go_left = 0;
      end
      if (go_left) e = line_error(p - 1, p);
      else if (go_right) e = line_error(p + 1, p);
      if (near_to(e, p) && !green_at(p + EDGE)) begin
        e = p * 4096; go_left = 0; go_right = 0;
      end else if (near_to(e, p - 1) && !green_at(p - 1 + EDGE)) begin
        p = p - 1; go_left = 0; go_right = 0; e = p * 4096;
      end else if (near_to(e, p + 1) && !green_at(p + 1 + EDGE)) begin
        p = p + 1; go_left = 0; go_right = 0; e = p * 4096;
      end
    end
    if (red_at(NSENS - 1)) begin
      e = EDGE * 4096; p = EDGE; go_left = 0; go_right = 0;
    end else if (red_at(0)) begin
      e = -EDGE * 4096; p = -EDGE; go_left = 0; go_right = 0;
    end else if (red_at(EDGE - 1)) begin
      p = -1; go_left = 0; go_right = 0;
    end else if (red_at(EDGE + 1)) begin
      p = 1; go_left = 0; go_right = 0;
    end else if (red_at(EDGE)) begin
      p = 0; go_left = 0; go_right = 0;
    end
    track_pos = p;
    e = sat16(e);
    pd = longint'(kp) * e + longint'(kd) * (longint'(e) - prev_err);
    pid = sat16(round_div(pd, 4096));
    ls = sat16(longint'(base_spd) + pid);
    rs = sat16(longint'(base_spd) - pid);
    prev_err = e;
    s.err = e[15:0];
    s.ls = ls[15:0];
    s.rs = rs[15:0];
    s.pos = p[2:0];
    s.ml = go_left;
    s.mr = go_right;
    s.stop = blue_hit;
    steer_q.push_back(s);
    red_seen = '0;
    grn_seen = '0;
    blue_hit = 0;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || took) begin
        if (!hold && reading_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          cur = reading_q.pop_front();
          command <= cur.run;
          sensor_index <= cur.idx;
          clear_level <= cur.clr;
          red_level <= cur.red;
          green_level <= cur.grn;
          blue_level <= cur.blu;
          frame_end <= cur.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    steer_t want;
    reading_t got_in;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        got_in.run = command;
        got_in.idx = sensor_index;
        got_in.clr = clear_level;
        got_in.red = red_level;
        got_in.grn = green_level;
        got_in.blu = blue_level;
        got_in.last = frame_end;
        predict_steering(got_in);
      end
      if (out_valid && !out_stall) begin
        if (steer_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected steering beat err=%0d", steer_error);
        end else begin
          want = steer_q.pop_front();
          if (want.err !== steer_error || want.ls !== left_speed || want.rs !== right_speed ||
              want.pos !== tracked_position || want.ml !== moving_left ||
              want.mr !== moving_right || want.stop !== stop_request) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp err=%0d l=%0d r=%0d pos=%0d ml=%0b mr=%0b stop=%0b %s%0d %0d %0d %0d %0b %0b %0b",
                       want.err, want.ls, want.rs, want.pos, want.ml, want.mr, want.stop,
                       "got ", steer_error, left_speed, right_speed, tracked_position,
                       moving_left, moving_right, stop_request);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic reading_t mk(bit run, int idx, int clr, int r, int g, int b, bit last);
    reading_t it;
    it.run = run;
    it.idx = idx[2:0];
    it.clr = clr[15:0];
    it.red = r[15:0];
    it.grn = g[15:0];
    it.blu = b[15:0];
    it.last = last;
    return it;
  endfunction

  function automatic int rand_level();
    case ($urandom_range(3))
      0: return $urandom_range(65535);
      1: return $urandom_range(3000);
      2: return 65535 - $urandom_range(3000);
      default: return 20000 + $urandom_range(25000);
    endcase
  endfunction

  task automatic add_reading(bit run, int idx, bit last);
    int r, g, b;
    r = $urandom_range(65535);
    g = $urandom_range(65535);
    b = $urandom_range(65535);
    case ($urandom_range(5))
      0: begin g = $urandom_range(2000); b = $urandom_range(2000); end
      1: begin r = $urandom_range(2000); b = $urandom_range(2000); end
      2: begin r = $urandom_range(2000); g = $urandom_range(2000); end
      3: begin r = 0; g = 0; b = 0; end
      default: ;
    endcase
    reading_q.push_back(mk(run, idx, rand_level(), r, g, b, last));
  endtask

  task automatic gen_traffic(int n);
    int cnt, k;
    cnt = 0;
    while (cnt < n) begin
      k = $urandom_range(99);
      if (k < 10) begin
        for (int s = 0; s < NSENS; s++)
          for (int j = $urandom_range(2); j >= 0; j--) begin
            add_reading(0, s, $urandom_range(1));
            cnt++;
          end
      end else if (k < 85) begin
        for (int s = 0; s < NSENS; s++) add_reading(1, s, s == NSENS - 1);
        cnt += NSENS;
      end else begin
        add_reading($urandom_range(1), $urandom_range(7), $urandom_range(1));
        cnt++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (reading_q.size() != 0 || in_valid || steer_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ix, int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val[15:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    case (ix)
      CFG_ON_LINE: on_line_thr = val & 16'h7FFF;
      CFG_NEAR: near_thr = val & 16'h7FFF;
      CFG_PROP_GAIN: kp = val & 16'hFFFF;
      CFG_DERIV_GAIN: kd = val & 16'hFFFF;
      CFG_BASE_SPEED: base_spd = val & 16'h1FFF;
      CFG_RED_RATIO: red_rat = val & 16'hFFFF;
      CFG_GREEN_RATIO: grn_rat = val & 16'hFFFF;
      CFG_BLUE_RATIO: blu_rat = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned a, int unsigned b, int unsigned c, int unsigned d,
                           int unsigned e, int unsigned f, int unsigned g, int unsigned h);
    write_reg(CFG_ON_LINE, a);
    write_reg(CFG_NEAR, b);
    write_reg(CFG_PROP_GAIN, c);
    write_reg(CFG_DERIV_GAIN, d);
    write_reg(CFG_BASE_SPEED, e);
    write_reg(CFG_RED_RATIO, f);
    write_reg(CFG_GREEN_RATIO, g);
    write_reg(CFG_BLUE_RATIO, h);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    snd_idle = 25;
    rcv_idle = 51;
    // one calibration sample leaves max below min on sensor 0
    reading_q.push_back(mk(0, 0, 1000, 0, 0, 0, 1));
    reading_q.push_back(mk(1, 0, 2000, 65535, 0, 0, 0));
    reading_q.push_back(mk(1, 1, 0, 0, 65535, 0, 0));
    reading_q.push_back(mk(1, 2, 65535, 0, 0, 65535, 0));
    reading_q.push_back(mk(1, 3, 0, 0, 0, 0, 0));
    reading_q.push_back(mk(1, 4, 65535, 65535, 65535, 65535, 1));
    for (int s = 0; s < NSENS; s++) begin
      reading_q.push_back(mk(0, s, 0, 0, 0, 0, 0));
      reading_q.push_back(mk(0, s, 65535, 0, 0, 0, 0));
    end
    reading_q.push_back(mk(1, 0, 100, 0, 0, 0, 0));
    reading_q.push_back(mk(1, 1, 30000, 0, 0, 0, 0));
    reading_q.push_back(mk(1, 2, 65535, 0, 0, 0, 0));
    reading_q.push_back(mk(1, 3, 5000, 0, 9000, 10, 0));
    reading_q.push_back(mk(1, 4, 65535, 40000, 1, 1, 1));
    // bad index still closes the frame, calibrate frame end gives nothing
    reading_q.push_back(mk(1, 7, 65535, 65535, 0, 0, 1));
    reading_q.push_back(mk(0, 5, 12345, 0, 0, 0, 1));
    reading_q.push_back(mk(1, 6, 0, 0, 0, 0, 1));
    gen_traffic(200);
    drain();
    write_all($urandom_range(16384), $urandom_range(16384), $urandom_range(65535),
              $urandom_range(65535), $urandom_range(4096), $urandom_range(65535),
              $urandom_range(65535), $urandom_range(65535));
    gen_traffic(200);
    drain();
    snd_idle = 51;
    rcv_idle = 25;
    write_all(16384, 16384, 65535, 65535, 4096, 65535, 65535, 65535);
    gen_traffic(100);
    do @(negedge clk); while (reading_q.size() != 0);
    hold = 1;
    do @(negedge clk); while (in_valid || steer_q.size() != 0);
    hold = 0;
    gen_traffic(100);
    drain();
    write_all(0, 0, 0, 0, 0, 0, 0, 0);
    gen_traffic(200);
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    write_all(9830, 1638, 369, 287, 901, 26870, 28180, 37356);
    gen_traffic(200);
    drain();
    write_all(32767, 32767, 4096, 20000, 8191, 1, 30000, 21845);
    gen_traffic(200);
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
